// ----- rtl/ttfm_pkg.sv -----
package ttfm_pkg;

	localparam int TTFM_TABLE_ROWS = 64;
	localparam int TTFM_VALUE_BITS = 32;

	localparam int FIELD_W   = 32;
	localparam int TOL_W     = 31;
	localparam int ROW_IDX_W = 6;
	localparam int CFG_IDX_W = 1;

	localparam logic [1:0] ACT_CLEAR  = 2'd0;
	localparam logic [1:0] ACT_APPEND = 2'd1;
	localparam logic [1:0] ACT_QUERY  = 2'd2;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_EMPTY   = 2'd1;
	localparam logic [1:0] STAT_NOMATCH = 2'd2;
	localparam logic [1:0] STAT_FULL    = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_TOL = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SPEED_TOL  = 1'd1;

	typedef struct packed {
		logic [1:0]                action;
		logic signed [FIELD_W-1:0] height;
		logic signed [FIELD_W-1:0] speed;
	} cmd_t;

	typedef struct packed {
		logic [1:0]           status;
		logic [ROW_IDX_W-1:0] row_index;
	} rsp_t;

	typedef struct packed {
		logic [TOL_W-1:0] height_tol;
		logic [TOL_W-1:0] speed_tol;
	} tol_t;

	// Control part of the query token that walks down the cell chain.
	typedef struct packed {
		logic                 valid;
		logic                 found;
		logic [ROW_IDX_W-1:0] idx;
	} tok_ctl_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DONE
	} state_t;

endpackage

// ----- rtl/ttfm_cell.sv -----
module ttfm_cell import ttfm_pkg::*; #(
	parameter int VALUE_BITS = TTFM_VALUE_BITS,
	parameter int CELL_INDEX = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  live,
	input  logic                  wr_en,
	input  logic [VALUE_BITS-1:0] wr_height,
	input  logic [VALUE_BITS-1:0] wr_speed,
	input  tol_t                  tol,
	input  tok_ctl_t              ctl_in,
	input  logic [VALUE_BITS-1:0] height_in,
	input  logic [VALUE_BITS-1:0] speed_in,
	output tok_ctl_t              ctl_out,
	output logic [VALUE_BITS-1:0] height_out,
	output logic [VALUE_BITS-1:0] speed_out
);

	localparam int CMP_W = (VALUE_BITS + 1 > TOL_W + 1) ? VALUE_BITS + 1 : TOL_W + 1;

	logic [VALUE_BITS-1:0]   row_height_q;
	logic [VALUE_BITS-1:0]   row_speed_q;
	tok_ctl_t                ctl_q;
	logic [VALUE_BITS-1:0]   height_q;
	logic [VALUE_BITS-1:0]   speed_q;

	logic signed [VALUE_BITS:0] dh;
	logic signed [VALUE_BITS:0] ds;
	logic signed [CMP_W-1:0]    dh_x;
	logic signed [CMP_W-1:0]    ds_x;
	logic signed [CMP_W-1:0]    th_x;
	logic signed [CMP_W-1:0]    ts_x;
	logic                       hit;
	tok_ctl_t                   ctl_d;

	// The differences carry one extra bit, so they never wrap.
	assign dh = $signed({height_in[VALUE_BITS-1], height_in})
		- $signed({row_height_q[VALUE_BITS-1], row_height_q});
	assign ds = $signed({speed_in[VALUE_BITS-1], speed_in})
		- $signed({row_speed_q[VALUE_BITS-1], row_speed_q});
	assign dh_x = CMP_W'(dh);
	assign ds_x = CMP_W'(ds);
	assign th_x = $signed(CMP_W'(tol.height_tol));
	assign ts_x = $signed(CMP_W'(tol.speed_tol));

	// An absolute value strictly below t is the same as -t < d < t.
	assign hit = (dh_x < th_x) && (dh_x > -th_x) && (ds_x < ts_x) && (ds_x > -ts_x);

	always_comb begin
		ctl_d = ctl_in;
		if (ctl_in.valid && !ctl_in.found && live && hit) begin
			ctl_d.found = 1'b1;
			ctl_d.idx   = ROW_IDX_W'(CELL_INDEX);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			row_height_q <= wr_height;
			row_speed_q  <= wr_speed;
		end
		height_q <= height_in;
		speed_q  <= speed_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q <= ctl_d;
		end
	end

	assign ctl_out    = ctl_q;
	assign height_out = height_q;
	assign speed_out  = speed_q;

endmodule

// ----- rtl/tolerance_table_first_match.sv -----
// Channel  Dir  Handshake            Payload
// cmd      in   cmd_valid/cmd_stall  cmd_t: action, height, speed
// rsp      out  rsp_valid/rsp_stall  rsp_t: status, row_index
// cfg      in   cfg_we               cfg_index, cfg_data (tolerances)
//
// A query walks the chain of TABLE_ROWS cells, one cell per cycle; its result is then
// registered and passes to the output register once that register is free.
// Clear, append and unused codes skip the chain. One transaction is in flight at a time;
// the next is accepted while the previous response still waits in the output register.
// Reset empties the table and clears the tolerances; row contents are not reset.
module tolerance_table_first_match import ttfm_pkg::*; #(
	parameter int TABLE_ROWS = TTFM_TABLE_ROWS,
	parameter int VALUE_BITS = TTFM_VALUE_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_stall,
	input  cmd_t                 cmd,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output rsp_t                 rsp,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TOL_W-1:0]     cfg_data
);

	localparam int CNT_W = $clog2(TABLE_ROWS + 1);
	localparam int IDX_W = (TABLE_ROWS > 1) ? $clog2(TABLE_ROWS) : 1;

	state_t              state_q, state_d;
	logic [CNT_W-1:0]    row_count_q;
	tol_t                tol_q;
	rsp_t                res_q, res_d;
	logic                res_load;
	logic                rsp_valid_q;
	rsp_t                rsp_q;
	logic                rsp_load;
	logic                cmd_fire;
	logic                inject;
	logic                clear_go;
	logic                append_go;
	logic                table_full;
	logic                table_empty;

	logic [VALUE_BITS-1:0] cmd_h;
	logic [VALUE_BITS-1:0] cmd_s;

	tok_ctl_t              chain_ctl    [0:TABLE_ROWS];
	logic [VALUE_BITS-1:0] chain_height [0:TABLE_ROWS];
	logic [VALUE_BITS-1:0] chain_speed  [0:TABLE_ROWS];

	generate
		if (VALUE_BITS <= FIELD_W) begin : g_narrow
			assign cmd_h = cmd.height[VALUE_BITS-1:0];
			assign cmd_s = cmd.speed[VALUE_BITS-1:0];
		end else begin : g_wide
			assign cmd_h = VALUE_BITS'(cmd.height);
			assign cmd_s = VALUE_BITS'(cmd.speed);
		end
	endgenerate

	assign table_full  = (row_count_q == CNT_W'(TABLE_ROWS));
	assign table_empty = (row_count_q == '0);
	assign cmd_fire    = cmd_valid && !cmd_stall;

	always_comb begin
		state_d   = state_q;
		cmd_stall = 1'b1;
		inject    = 1'b0;
		clear_go  = 1'b0;
		append_go = 1'b0;
		res_load  = 1'b0;
		res_d     = '0;
		rsp_load  = 1'b0;
		case (state_q)
			S_IDLE: begin
				cmd_stall = 1'b0;
				if (cmd_valid) begin
					res_load = 1'b1;
					state_d  = S_DONE;
					case (cmd.action)
						ACT_CLEAR: begin
							clear_go = 1'b1;
						end
						ACT_APPEND: begin
							if (table_full) begin
								res_d.status = STAT_FULL;
							end else begin
								append_go = 1'b1;
							end
						end
						ACT_QUERY: begin
							if (table_empty) begin
								res_d.status = STAT_EMPTY;
							end else begin
								inject   = 1'b1;
								res_load = 1'b0;
								state_d  = S_SCAN;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_SCAN: begin
				if (chain_ctl[TABLE_ROWS].valid) begin
					res_load = 1'b1;
					state_d  = S_DONE;
					if (chain_ctl[TABLE_ROWS].found) begin
						res_d.status    = STAT_OK;
						res_d.row_index = chain_ctl[TABLE_ROWS].idx;
					end else begin
						res_d.status = STAT_NOMATCH;
					end
				end
			end
			S_DONE: begin
				if (!rsp_valid_q || !rsp_stall) begin
					rsp_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			row_count_q <= '0;
			tol_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clear_go) begin
				row_count_q <= '0;
			end else if (append_go) begin
				row_count_q <= row_count_q + CNT_W'(1);
			end
			if (cfg_we) begin
				if (cfg_index == CFG_HEIGHT_TOL) begin
					tol_q.height_tol <= cfg_data;
				end
				if (cfg_index == CFG_SPEED_TOL) begin
					tol_q.speed_tol <= cfg_data;
				end
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res_d;
		end
		if (rsp_load) begin
			rsp_q <= res_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// The head of the chain takes the query straight from the command.
	always_comb begin
		chain_ctl[0]       = '0;
		chain_ctl[0].valid = inject;
	end
	assign chain_height[0] = cmd_h;
	assign chain_speed[0]  = cmd_s;

	generate
		for (genvar i = 0; i < TABLE_ROWS; i++) begin : g_cell
			logic live;
			logic wr_en;

			assign live  = (row_count_q > CNT_W'(i));
			assign wr_en = append_go && (row_count_q[IDX_W-1:0] == IDX_W'(i));

			ttfm_cell #(
				.VALUE_BITS (VALUE_BITS),
				.CELL_INDEX (i)
			) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.live       (live),
				.wr_en      (wr_en),
				.wr_height  (cmd_h),
				.wr_speed   (cmd_s),
				.tol        (tol_q),
				.ctl_in     (chain_ctl[i]),
				.height_in  (chain_height[i]),
				.speed_in   (chain_speed[i]),
				.ctl_out    (chain_ctl[i+1]),
				.height_out (chain_height[i+1]),
				.speed_out  (chain_speed[i+1])
			);
		end
	endgenerate

	a_tail_only_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		chain_ctl[TABLE_ROWS].valid |-> state_q == S_SCAN)
		else $error("query token left the chain outside a scan");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		row_count_q <= CNT_W'(TABLE_ROWS))
		else $error("row count exceeds table size");

	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == S_DONE)
		else $error("response raised without a finished transaction");

	a_inject_scans: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_fire && inject |=> state_q == S_SCAN && !cmd_stall == 1'b0)
		else $error("query injected without entering the scan");

endmodule

// ----- tb/tb_tolerance_table_first_match.sv -----
`timescale 1ns / 100ps

module tb_tolerance_table_first_match import ttfm_pkg::*;;

	localparam int CLK_PERIOD  = 10;
	localparam int RESET_LEN   = 9;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int LONG_HOLD   = 300;
	localparam int SETTLE      = TTFM_TABLE_ROWS + 8;

	// The block ignores this action code apart from a plain OK response.
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	localparam logic [FIELD_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
	localparam logic [FIELD_W-1:0] VAL_MIN = 32'h8000_0000;
	localparam logic [TOL_W-1:0]   TOL_MAX = 31'h7FFF_FFFF;
	localparam logic [TOL_W-1:0]   Q_ONE   = 31'h0001_0000;

	class row_table_scoreboard;
		logic signed [FIELD_W-1:0] heights [TTFM_TABLE_ROWS];
		logic signed [FIELD_W-1:0] speeds [TTFM_TABLE_ROWS];
		int unsigned rows;
		logic [TOL_W-1:0] h_tol;
		logic [TOL_W-1:0] s_tol;
		rsp_t expected_q[$];
		int errors;
		int responses;
		int hits;
		int misses;
		int empties;
		int fulls;

		function new();
			rows = 0;
			h_tol = '0;
			s_tol = '0;
			errors = 0;
			responses = 0;
			hits = 0;
			misses = 0;
			empties = 0;
			fulls = 0;
		endfunction

		function void write_tolerance(logic [CFG_IDX_W-1:0] idx, logic [TOL_W-1:0] value);
			if (idx == CFG_HEIGHT_TOL) begin
				h_tol = value;
			end else if (idx == CFG_SPEED_TOL) begin
				s_tol = value;
			end
		endfunction

		// Differences are formed at 64 bits, so they cannot wrap.
		function bit close_enough(logic signed [FIELD_W-1:0] a, logic signed [FIELD_W-1:0] b,
				logic [TOL_W-1:0] tol);
			longint d;
			d = longint'(a) - longint'(b);
			if (d < 0) begin
				d = -d;
			end
			return d < longint'(tol);
		endfunction

		function void note_command(cmd_t c);
			rsp_t r;
			bit found;
			r.status = STAT_OK;
			r.row_index = '0;
			found = 1'b0;
			case (c.action)
				ACT_CLEAR: begin
					rows = 0;
				end
				ACT_APPEND: begin
					if (rows >= TTFM_TABLE_ROWS) begin
						r.status = STAT_FULL;
						fulls++;
					end else begin
						heights[rows] = c.height;
						speeds[rows] = c.speed;
						rows++;
					end
				end
				ACT_QUERY: begin
					if (rows == 0) begin
						r.status = STAT_EMPTY;
						empties++;
					end else begin
						for (int i = 0; i < rows; i++) begin
							if (!found && close_enough(c.height, heights[i], h_tol) &&
									close_enough(c.speed, speeds[i], s_tol)) begin
								found = 1'b1;
								r.row_index = i[ROW_IDX_W-1:0];
							end
						end
						if (found) begin
							hits++;
						end else begin
							r.status = STAT_NOMATCH;
							misses++;
						end
					end
				end
				default: ;
			endcase
			expected_q.insert(expected_q.size(), r);
		endfunction

		task report_mismatch(string msg);
			$display("MISMATCH at %0t: %s", $time, msg);
			errors++;
		endtask

		task check_response(rsp_t got);
			rsp_t want;
			responses++;
			if (expected_q.size() == 0) begin
				report_mismatch($sformatf("response %0d/%0d with no transaction pending",
					got.status, got.row_index));
			end else begin
				want = expected_q.pop_front();
				if (got.status !== want.status) begin
					report_mismatch($sformatf("status %0d, expected %0d",
						got.status, want.status));
				end
				if (got.row_index !== want.row_index) begin
					report_mismatch($sformatf("row_index %0d, expected %0d",
						got.row_index, want.row_index));
				end
			end
		endtask
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cmd_valid = 1'b0;
	logic                 cmd_stall;
	cmd_t                 cmd = '0;
	logic                 rsp_valid;
	logic                 rsp_stall = 1'b0;
	rsp_t                 rsp;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [TOL_W-1:0]     cfg_data = '0;

	row_table_scoreboard sb = new();

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_asked = 0;
	int hold_taken = 0;
	int hold_left = 0;
	int cycle_count = 0;
	int items_sent = 0;
	int tol_settings = 0;

	tolerance_table_first_match uut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Receiver: random stalls, or a long hold-off when the stimulus asks for one.
	always @(posedge clk) begin
		if (hold_asked != hold_taken) begin
			hold_taken = hold_taken + 1;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			sb.check_response(rsp);
		end
	end

	task send_cmd(cmd_t c);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		do begin
			@(posedge clk);
		end while (cmd_stall);
		sb.note_command(c);
		if (c.action != ACT_UNUSED) begin
			items_sent++;
		end
	endtask

	task send_fields(logic [1:0] act, logic [FIELD_W-1:0] h, logic [FIELD_W-1:0] s);
		cmd_t c;
		c.action = act;
		c.height = h;
		c.speed = s;
		send_cmd(c);
	endtask

	task wait_drained();
		cmd_valid <= 1'b0;
		while (sb.expected_q.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task set_tolerances(logic [TOL_W-1:0] h_tol, logic [TOL_W-1:0] s_tol);
		wait_drained();
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_HEIGHT_TOL;
		cfg_data <= h_tol;
		@(posedge clk);
		sb.write_tolerance(CFG_HEIGHT_TOL, h_tol);
		cfg_index <= CFG_SPEED_TOL;
		cfg_data <= s_tol;
		@(posedge clk);
		sb.write_tolerance(CFG_SPEED_TOL, s_tol);
		cfg_we <= 1'b0;
		tol_settings++;
	endtask

	// Row values: mostly clustered around a center so that several rows
	// can match one query, with some full-range values and extremes.
	function automatic logic [FIELD_W-1:0] row_value(logic signed [FIELD_W-1:0] center,
			logic [TOL_W-1:0] tol);
		int unsigned m;
		longint spread;
		m = $urandom_range(0, 9);
		spread = 4 * longint'(tol) + 8;
		if (m < 2) begin
			return $urandom;
		end else if (m == 2) begin
			return $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
		end
		return FIELD_W'(longint'(center) + (longint'($urandom) % spread) - spread / 2);
	endfunction

	// Query values near a stored one, often right at the tolerance edge.
	function automatic logic [FIELD_W-1:0] query_value(logic signed [FIELD_W-1:0] stored,
			logic [TOL_W-1:0] tol);
		longint t;
		longint off;
		t = longint'(tol);
		case ($urandom_range(0, 5))
			0: off = 0;
			1: off = t - 1;
			2: off = 1 - t;
			3: off = $urandom_range(0, 1) ? t : -t;
			4: off = (longint'($urandom) % (2 * t + 1)) - t;
			default: return $urandom;
		endcase
		return FIELD_W'(longint'(stored) + off);
	endfunction

	task send_query();
		int unsigned k;
		int unsigned k2;
		if (sb.rows == 0) begin
			send_fields(ACT_QUERY, $urandom, $urandom);
		end else begin
			k = $urandom_range(0, sb.rows - 1);
			k2 = ($urandom_range(0, 3) == 0) ? $urandom_range(0, sb.rows - 1) : k;
			send_fields(ACT_QUERY, query_value(sb.heights[k], sb.h_tol),
				query_value(sb.speeds[k2], sb.s_tol));
		end
	endtask

	// Mostly clear / fill / query sequences; the rest is random noise.
	task run_random(int n_items);
		int stop_at;
		int n_rows;
		logic signed [FIELD_W-1:0] center_h;
		logic signed [FIELD_W-1:0] center_s;
		stop_at = items_sent + n_items;
		while (items_sent < stop_at) begin
			if ($urandom_range(0, 99) < 85) begin
				if ($urandom_range(0, 2) != 0) begin
					send_fields(ACT_CLEAR, $urandom, $urandom);
				end
				n_rows = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 68) :
					$urandom_range(0, 8);
				center_h = $urandom;
				center_s = $urandom;
				repeat (n_rows) begin
					send_fields(ACT_APPEND, row_value(center_h, sb.h_tol),
						row_value(center_s, sb.s_tol));
				end
				repeat ($urandom_range(1, 6)) send_query();
			end else begin
				send_fields(2'($urandom_range(0, 3)), $urandom, $urandom);
			end
		end
	endtask

	initial begin
		repeat (RESET_LEN) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 6;
		recv_idle_pct = 82;

		// Tolerances are still zero after reset: nothing can match.
		send_fields(ACT_QUERY, 32'h5, 32'h7);
		send_fields(ACT_UNUSED, VAL_MAX, VAL_MIN);
		send_fields(ACT_APPEND, VAL_MAX, VAL_MIN);
		send_fields(ACT_QUERY, VAL_MAX, VAL_MIN);
		send_fields(ACT_CLEAR, '0, '0);
		send_fields(ACT_QUERY, '0, '0);

		set_tolerances(TOL_MAX, TOL_MAX);
		send_fields(ACT_APPEND, VAL_MIN, VAL_MIN);
		send_fields(ACT_APPEND, '0, '0);
		send_fields(ACT_APPEND, VAL_MAX, VAL_MAX);
		send_fields(ACT_QUERY, VAL_MAX, VAL_MAX);
		send_fields(ACT_QUERY, VAL_MIN, VAL_MIN);
		send_fields(ACT_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

		// One-unit tolerances: a difference equal to the bound must fail,
		// and the first of two identical rows must win.
		set_tolerances(Q_ONE, Q_ONE);
		send_fields(ACT_CLEAR, '0, '0);
		send_fields(ACT_APPEND, 32'h0001_0000, 32'h0002_0000);
		send_fields(ACT_APPEND, 32'h0001_0000, 32'h0001_0000);
		send_fields(ACT_APPEND, 32'h0001_0000, 32'h0001_0000);
		send_fields(ACT_QUERY, 32'h0002_0000, 32'h0001_0000);
		send_fields(ACT_QUERY, 32'h0001_FFFF, 32'h0001_0000);
		send_fields(ACT_QUERY, 32'h0000_0001, 32'h0001_FFFF);

		set_tolerances(Q_ONE, 31'h0000_8000);
		run_random(120);
		hold_asked++;
		run_random(126);

		set_tolerances(TOL_MAX, TOL_MAX);
		run_random(200);

		send_idle_pct = 82;
		recv_idle_pct = 6;
		set_tolerances(31'd1, 31'd1);
		run_random(200);
		set_tolerances('0, '0);
		run_random(60);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_tolerances(TOL_MAX, 31'd3);
		run_random(200);
		set_tolerances(31'($urandom_range(1, 32'h0004_0000)), 31'($urandom_range(1, 32'h0004_0000)));
		run_random(200);
		hold_asked++;
		run_random(60);

		wait_drained();
		repeat (SETTLE) @(posedge clk);

		$display("Covered %0d transactions under %0d tolerance settings: %0d matches,",
			items_sent, tol_settings, sb.hits);
		$display("%0d misses, %0d queries on an empty table and %0d appends to a full one.",
			sb.misses, sb.empties, sb.fulls);
		if (sb.errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
